[src/tks_pkg.sv]
// ----------------------------------------------------------------------------
// tks_pkg
// Shared constants and types for the streaming top-K score selector.
// ----------------------------------------------------------------------------
package tks_pkg;

    // Number of best scores kept for each row
    localparam int KEEP_COUNT = 5;
    // Longest row the position counter tells apart
    localparam int ROW_MAX    = 4096;

    // Field widths of the transaction payloads
    localparam int SCORE_W = 16;
    localparam int POS_W   = 12;
    localparam int RANK_W  = 3;
    // Width of the drain counter: holds 0 .. KEEP_COUNT
    localparam int CNT_W   = $clog2(KEEP_COUNT + 1);

    // Score of an unfilled slot: -1.0 in Q1.15
    localparam logic [SCORE_W-1:0] SCORE_SENTINEL = {1'b1, {(SCORE_W-1){1'b0}}};
    // Last position before the counter saturates
    localparam logic [POS_W-1:0]   POS_LAST       = POS_W'(ROW_MAX - 1);

    // One slot of the best list
    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic        [POS_W-1:0]   pos;
    } tks_slot_t;

    // Controls for a list cell
    typedef struct packed {
        logic take;   // an input transaction is accepted
        logic clear;  // that transaction ends the row
    } tks_list_ctrl_t;

    // Controls for a drain cell
    typedef struct packed {
        logic load;   // capture the finished list
        logic shift;  // move one place towards the head
    } tks_drain_ctrl_t;

endpackage

[src/tks_list_cell.sv]
// ----------------------------------------------------------------------------
// tks_list_cell
// One slot of the sorted best list: compares the new score, then keeps,
// replaces or takes its upper neighbour's entry.
// ----------------------------------------------------------------------------
module tks_list_cell
    import tks_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  tks_list_ctrl_t             ctrl,
    input  logic signed [SCORE_W-1:0]  new_score,
    input  logic        [POS_W-1:0]    new_pos,
    input  logic                       up_gt,
    input  tks_slot_t                  up_slot,
    output logic                       gt,
    output tks_slot_t                  slot,
    output tks_slot_t                  slot_next
);

    tks_slot_t slot_reg;

    // New score strictly above this slot
    assign gt = new_score > slot_reg.score;

    // Shift down when the insertion point is above, insert when it is here
    always_comb begin
        if (up_gt) begin
            slot_next = up_slot;
        end else if (gt) begin
            slot_next.score = new_score;
            slot_next.pos   = new_pos;
        end else begin
            slot_next = slot_reg;
        end
    end

    // Row end returns the slot to its empty value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg.score <= SCORE_SENTINEL;
            slot_reg.pos   <= '0;
        end else if (ctrl.take) begin
            if (ctrl.clear) begin
                slot_reg.score <= SCORE_SENTINEL;
                slot_reg.pos   <= '0;
            end else begin
                slot_reg <= slot_next;
            end
        end
    end

    assign slot = slot_reg;

endmodule

[src/tks_drain_cell.sv]
// ----------------------------------------------------------------------------
// tks_drain_cell
// One stage of the output shift chain that replays a finished list in rank
// order.
// ----------------------------------------------------------------------------
module tks_drain_cell
    import tks_pkg::*;
(
    input  logic            aclk,
    input  tks_drain_ctrl_t ctrl,
    input  tks_slot_t       load_slot,
    input  tks_slot_t       down_slot,
    output tks_slot_t       slot
);

    tks_slot_t slot_reg;

    // Payload only: the drain counter says which stages are meaningful
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            slot_reg <= load_slot;
        end else if (ctrl.shift) begin
            slot_reg <= down_slot;
        end
    end

    assign slot = slot_reg;

endmodule

[src/top_k_score_selector.sv]
// ----------------------------------------------------------------------------
// top_k_score_selector
// Streaming selection of the best KEEP_COUNT scores of each row.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_): one score per transaction, s_row_end on the last score
//   of a row. The position of a score is its index in the row, saturating at
//   ROW_MAX-1. Scores within a row are taken one per cycle, every cycle.
//   Output channel (m_): on a row end the block gives KEEP_COUNT transactions,
//   ranks 0 to KEEP_COUNT-1 in descending score order, m_final_rank on the
//   last. Unfilled slots read -1.0 with position 0; equal scores keep the
//   earlier position ahead.
//   The rank 0 result is valid the cycle after the row end is taken; the run
//   then drains at one result per cycle while m_ready is high.
//   The list is a chain of KEEP_COUNT compare cells that test a new score in
//   parallel; the finished list is copied into a KEEP_COUNT stage shift chain,
//   so the next row streams in while the previous one drains. A row end is
//   held off (s_ready low with s_row_end high) until that chain is empty.
//   A stalled receiver only holds the drain chain; mid-row scores still enter.
//   Reset (aresetn low, synchronous) empties the list and clears the position
//   and drain counters; the output chain is not reset but reads as empty.
// ----------------------------------------------------------------------------
module top_k_score_selector
    import tks_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [SCORE_W-1:0] s_score,
    input  logic                      s_row_end,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic        [RANK_W-1:0]  m_rank,
    output logic        [POS_W-1:0]   m_position,
    output logic signed [SCORE_W-1:0] m_best_score,
    output logic                      m_final_rank
);

    logic               take;
    logic               row_done;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               out_take;

    tks_list_ctrl_t     list_ctrl;
    tks_drain_ctrl_t    drain_ctrl;

    logic               gt    [KEEP_COUNT];
    tks_slot_t          slots [KEEP_COUNT];
    tks_slot_t          nexts [KEEP_COUNT];
    tks_slot_t          drain [KEEP_COUNT];

    // Input handshake: a row end waits for the drain chain to empty
    assign s_ready  = !s_row_end || (cnt_reg == '0);
    assign take     = s_valid && s_ready;
    assign row_done = take && s_row_end;
    assign out_take = m_valid && m_ready;

    assign list_ctrl.take   = take;
    assign list_ctrl.clear  = s_row_end;
    assign drain_ctrl.load  = row_done;
    assign drain_ctrl.shift = out_take;

    // Position counter, saturating, cleared at row end
    always_comb begin
        pos_next = pos_reg;
        if (take) begin
            if (s_row_end) begin
                pos_next = '0;
            end else if (pos_reg != POS_LAST) begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    // Drain counter: results still to deliver
    always_comb begin
        cnt_next = cnt_reg;
        if (row_done) begin
            cnt_next = CNT_W'(KEEP_COUNT);
        end else if (out_take) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            cnt_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            cnt_reg <= cnt_next;
        end
    end

    // Chain of list cells and drain cells
    genvar i;
    generate
        for (i = 0; i < KEEP_COUNT; i++) begin : g_cell
            logic      up_gt;
            tks_slot_t up_slot;
            tks_slot_t down_slot;

            if (i == 0) begin : g_head
                assign up_gt   = 1'b0;
                assign up_slot = slots[0];
            end else begin : g_body
                assign up_gt   = gt[i-1];
                assign up_slot = slots[i-1];
            end

            if (i == KEEP_COUNT - 1) begin : g_tail
                assign down_slot = drain[i];
            end else begin : g_inner
                assign down_slot = drain[i+1];
            end

            tks_list_cell u_list (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (list_ctrl),
                .new_score (s_score),
                .new_pos   (pos_reg),
                .up_gt     (up_gt),
                .up_slot   (up_slot),
                .gt        (gt[i]),
                .slot      (slots[i]),
                .slot_next (nexts[i])
            );

            tks_drain_cell u_drain (
                .aclk      (aclk),
                .ctrl      (drain_ctrl),
                .load_slot (nexts[i]),
                .down_slot (down_slot),
                .slot      (drain[i])
            );
        end
    endgenerate

    // Output from the head of the drain chain
    assign m_valid      = cnt_reg != '0;
    assign m_rank       = RANK_W'(KEEP_COUNT) - RANK_W'(cnt_reg);
    assign m_position   = drain[0].pos;
    assign m_best_score = drain[0].score;
    assign m_final_rank = cnt_reg == CNT_W'(1);

endmodule

[src/tks_checker.sv]
// ----------------------------------------------------------------------------
// tks_checker
// Port-level checks on the top-K selector's result runs.
// ----------------------------------------------------------------------------
module tks_checker
    import tks_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      s_row_end,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic        [RANK_W-1:0]  m_rank,
    input logic        [POS_W-1:0]   m_position,
    input logic signed [SCORE_W-1:0] m_best_score,
    input logic                      m_final_rank
);

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rank) && $stable(m_position)
            && $stable(m_best_score) && $stable(m_final_rank))
        else $error("result changed while stalled");

    // The final flag sits on the last rank, KEEP_COUNT-1, only
    a_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_final_rank == (m_rank == RANK_W'(KEEP_COUNT - 1))))
        else $error("final flag on wrong rank");

    // Ranks of a run follow one another without gaps
    a_next: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_final_rank |=>
            m_valid && (m_rank == $past(m_rank) + 1'b1))
        else $error("rank sequence broken");

    // A taken row end starts a run at rank 0
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_row_end |=> m_valid && (m_rank == '0))
        else $error("row end did not start a run");

endmodule

bind top_k_score_selector tks_checker u_tks_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_row_end    (s_row_end),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_rank       (m_rank),
    .m_position   (m_position),
    .m_best_score (m_best_score),
    .m_final_rank (m_final_rank)
);
